@@ rtl/core/ffe_pkg.sv @@
// shared widths, codes and types for the framebuffer fill engine
package ffe_pkg;

  localparam int DIM_W   = 12;  // surface width and height registers
  localparam int PITCH_W = 14;  // row pitch register, widest config register
  localparam int COORD_W = 16;  // request coordinates and rectangle sizes
  localparam int COLOR_W = 8;
  localparam int PIXEL_W = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W  = PITCH_W + DIM_W;  // pitch times row
  localparam int OFF_W   = PROD_W + 1;       // byte offset with column added

  localparam int MEM_BYTES_DEF = 1048576;

  localparam logic [DIM_W-1:0]   MAX_WIDTH  = 12'd2048;
  localparam logic [DIM_W-1:0]   MAX_HEIGHT = 12'd2048;
  localparam logic [PITCH_W-1:0] MAX_PITCH  = 14'd8192;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOB     = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd2;

  // one access of the pixel store
  typedef struct packed {
    logic               wr;
    logic               rd;
    logic [OFF_W-1:0]   off;    // byte offset of the pixel
    logic [PIXEL_W-1:0] color;  // red in the low byte
  } store_req_t;

endpackage

@@ rtl/core/ffe_req_if.sv @@
// request channel of the framebuffer fill engine
interface ffe_req_if;
  import ffe_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] alpha;

  modport source (
    output valid, kind, x_coord, y_coord, rect_width, rect_height,
           red, green, blue, alpha,
    input  ready
  );

  modport sink (
    input  valid, kind, x_coord, y_coord, rect_width, rect_height,
           red, green, blue, alpha,
    output ready
  );

endinterface

@@ rtl/core/ffe_rsp_if.sv @@
// result channel of the framebuffer fill engine
interface ffe_rsp_if;
  import ffe_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [PIXEL_W-1:0] pixel_value;

  modport source (
    output valid, status, pixel_value,
    input  ready
  );

  modport sink (
    input  valid, status, pixel_value,
    output ready
  );

endinterface

@@ rtl/core/ffe_mul.sv @@
// shared pitch times row multiplier with registered product
module ffe_mul (
  input  logic                        clk,
  input  logic [ffe_pkg::PITCH_W-1:0] pitch,
  input  logic [ffe_pkg::DIM_W-1:0]   row,
  output logic [ffe_pkg::PROD_W-1:0]  prod
);
  import ffe_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(pitch) * PROD_W'(row);
  end

endmodule

@@ rtl/core/ffe_store.sv @@
// pixel byte store split into four byte banks, one pixel access per cycle
module ffe_store #(
  parameter int MEM_BYTES = ffe_pkg::MEM_BYTES_DEF
) (
  input  logic                        clk,
  input  ffe_pkg::store_req_t         req,
  output logic [ffe_pkg::PIXEL_W-1:0] rd_pixel
);
  import ffe_pkg::*;

  localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [1:0]         lane;
  logic [OFF_W-3:0]   base;
  logic [COLOR_W-1:0] rd_byte [4];
  logic [1:0]         rd_lane;

  assign lane = req.off[1:0];
  assign base = req.off[OFF_W-1:2];

  // byte k of the pixel sits in bank (lane + k) mod 4
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [COLOR_W-1:0] mem [BANK_DEPTH];
    logic [1:0]         k;
    logic [OFF_W-3:0]   row_sum;
    logic [IDX_W-1:0]   idx;

    assign k       = 2'(b) - lane;
    assign row_sum = base + ((2'(b) < lane) ? (OFF_W-2)'(1) : (OFF_W-2)'(0));
    assign idx     = row_sum[IDX_W-1:0];

    always_ff @(posedge clk) begin
      if (req.wr) begin
        mem[idx] <= req.color[k*COLOR_W +: COLOR_W];
      end
      if (req.rd) begin
        rd_byte[b] <= mem[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_lane <= lane;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rd_pixel[k*COLOR_W +: COLOR_W] = rd_byte[2'(rd_lane + 2'(k))];
    end
  end

endmodule

@@ rtl/core/framebuffer_fill_engine_unit.sv @@
// top level of the framebuffer fill engine: sequencer, config registers, result register
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      kind, x_coord, y_coord, rect_width, rect_height, rgba
//   rsp      out  valid / ready      status, pixel_value
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// after reset the store is swept to zero one bank row a cycle, across all (MEM_BYTES+3)/4
// bank rows (262144 at the default size); requests wait, config writes are taken.
// a request is checked in S_CHECK and S_VERIFY, then a fill or clear paints one pixel
// a cycle, with an S_ROW step before each row to load the shared multiplier.
// a read goes through S_RADDR, S_RISSUE and S_RWAIT; a rejected request goes to S_DONE.
// the result register frees the sequencer, so a new request is taken while a result waits.
module framebuffer_fill_engine_unit #(
  parameter int MEM_BYTES = ffe_pkg::MEM_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  ffe_req_if.sink                       req,
  ffe_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [ffe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffe_pkg::PITCH_W-1:0]   cfg_data
);
  import ffe_pkg::*;

  localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] S_INIT   = 4'd0;  // clearing sweep after reset
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;  // pitch * height into multiplier
  localparam logic [3:0] S_VERIFY = 4'd3;  // surface and bounds checks
  localparam logic [3:0] S_ROW    = 4'd4;  // row base into multiplier
  localparam logic [3:0] S_PAINT  = 4'd5;  // one pixel a cycle along the row
  localparam logic [3:0] S_RADDR  = 4'd6;
  localparam logic [3:0] S_RISSUE = 4'd7;
  localparam logic [3:0] S_RWAIT  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state;

  // config registers
  logic [DIM_W-1:0]   surf_width;
  logic [DIM_W-1:0]   surf_height;
  logic [PITCH_W-1:0] row_pitch;

  // latched request
  logic [KIND_W-1:0]  kind_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [COORD_W-1:0] w_q;
  logic [COORD_W-1:0] h_q;
  logic [PIXEL_W-1:0] color_q;

  // walk counters
  logic [DIM_W-1:0] col;
  logic [DIM_W-1:0] col_first;
  logic [DIM_W-1:0] col_last;
  logic [DIM_W-1:0] row;
  logic [DIM_W-1:0] row_last;
  logic [IDX_W-1:0] clr_idx;

  // result being built and result register
  logic [STAT_W-1:0]  status_q;
  logic [PIXEL_W-1:0] pix_q;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [PIXEL_W-1:0] out_pixel;

  // datapath
  logic [PITCH_W-1:0] width4;
  logic [PITCH_W-1:0] pitch_eff;
  logic [DIM_W-1:0]   mul_row;
  logic [PROD_W-1:0]  prod;
  logic               surf_ok;
  logic [COORD_W:0]   x_end;
  logic [COORD_W:0]   y_end;
  logic               fill_oob;
  logic               read_oob;
  logic [OFF_W-1:0]   paint_off;
  store_req_t         st_req;
  logic [PIXEL_W-1:0] rd_pixel;

  assign width4    = {surf_width, 2'b00};
  assign pitch_eff = (row_pitch == '0) ? width4 : row_pitch;

  // the one multiplier: surface size during the check, row base afterwards
  assign mul_row = (state == S_CHECK) ? surf_height : row;

  ffe_mul u_mul (
    .clk   (clk),
    .pitch (pitch_eff),
    .row   (mul_row),
    .prod  (prod)
  );

  // prod holds pitch * height while in S_VERIFY
  assign surf_ok = (surf_width != '0) && (surf_height != '0)
                && (surf_width <= MAX_WIDTH) && (surf_height <= MAX_HEIGHT)
                && (pitch_eff >= width4) && (pitch_eff <= MAX_PITCH)
                && (prod <= PROD_W'(MEM_BYTES));

  // exact sums, one bit wider than the coordinates
  assign x_end    = {1'b0, x_q} + {1'b0, w_q};
  assign y_end    = {1'b0, y_q} + {1'b0, h_q};
  assign fill_oob = (x_end > (COORD_W+1)'(surf_width))
                 || (y_end > (COORD_W+1)'(surf_height));
  assign read_oob = (x_q >= COORD_W'(surf_width)) || (y_q >= COORD_W'(surf_height));

  // pixel offset: row base from the multiplier plus four bytes per column
  assign paint_off = OFF_W'(prod) + OFF_W'({col, 2'b00});

  always_comb begin
    st_req = '0;
    case (state)
      S_INIT: begin
        st_req.wr  = 1'b1;
        st_req.off = OFF_W'({clr_idx, 2'b00});
      end
      S_PAINT: begin
        st_req.wr    = 1'b1;
        st_req.off   = paint_off;
        st_req.color = color_q;
      end
      S_RISSUE: begin
        st_req.rd  = 1'b1;
        st_req.off = paint_off;
      end
      default: begin
      end
    endcase
  end

  ffe_store #(
    .MEM_BYTES (MEM_BYTES)
  ) u_store (
    .clk      (clk),
    .req      (st_req),
    .rd_pixel (rd_pixel)
  );

  // config port, to be written only while no request is in flight; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      surf_width  <= '0;
      surf_height <= '0;
      row_pitch   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  surf_width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: surf_height <= cfg_data[DIM_W-1:0];
        CFG_PITCH:  row_pitch   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  // request capture, payload only
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_q  <= req.kind;
      x_q     <= req.x_coord;
      y_q     <= req.y_coord;
      w_q     <= req.rect_width;
      h_q     <= req.rect_height;
      color_q <= {req.alpha, req.blue, req.green, req.red};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      clr_idx <= '0;
    end else begin
      case (state)
        S_INIT: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(BANK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            pix_q    <= '0;
            status_q <= ST_OK;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_VERIFY;
        end
        S_VERIFY: begin
          if (!surf_ok) begin
            status_q <= ST_INVALID;
            state    <= S_DONE;
          end else begin
            case (kind_q)
              KIND_CLEAR: begin
                col       <= '0;
                col_first <= '0;
                col_last  <= surf_width - DIM_W'(1);
                row       <= '0;
                row_last  <= surf_height - DIM_W'(1);
                state     <= S_ROW;
              end
              KIND_FILL: begin
                if (fill_oob) begin
                  status_q <= ST_OOB;
                  state    <= S_DONE;
                end else if (w_q == '0 || h_q == '0) begin
                  // empty rectangle inside the surface: nothing to paint
                  state <= S_DONE;
                end else begin
                  col       <= x_q[DIM_W-1:0];
                  col_first <= x_q[DIM_W-1:0];
                  col_last  <= DIM_W'(x_end - (COORD_W+1)'(1));
                  row       <= y_q[DIM_W-1:0];
                  row_last  <= DIM_W'(y_end - (COORD_W+1)'(1));
                  state     <= S_ROW;
                end
              end
              KIND_READ: begin
                if (read_oob) begin
                  status_q <= ST_OOB;
                  state    <= S_DONE;
                end else begin
                  col   <= x_q[DIM_W-1:0];
                  row   <= y_q[DIM_W-1:0];
                  state <= S_RADDR;
                end
              end
              default: begin
                // unused kind
                status_q <= ST_OOB;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_ROW: begin
          state <= S_PAINT;
        end
        S_PAINT: begin
          if (col == col_last) begin
            if (row == row_last) begin
              state <= S_DONE;
            end else begin
              row   <= row + DIM_W'(1);
              col   <= col_first;
              state <= S_ROW;
            end
          end else begin
            col <= col + DIM_W'(1);
          end
        end
        S_RADDR: begin
          state <= S_RISSUE;
        end
        S_RISSUE: begin
          state <= S_RWAIT;
        end
        S_RWAIT: begin
          pix_q <= rd_pixel;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp.ready)) begin
      out_status <= status_q;
      out_pixel  <= pix_q;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.pixel_value = out_pixel;

`ifndef SYNTHESIS
  // painting never leaves the rectangle being walked
  a_paint_in_rect: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAINT) |-> (col <= col_last && row <= row_last))
    else $error("paint walk left its rectangle");

  // every painted pixel lies fully inside the store
  a_paint_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == S_PAINT) |-> (paint_off + OFF_W'(3) < OFF_W'(MEM_BYTES)))
    else $error("paint offset beyond the store");

  // a new result appears only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the done state");

  // read data is captured in the cycle after the store read
  a_read_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWAIT) |-> ($past(state) == S_RISSUE))
    else $error("read capture without a store read");
`endif

endmodule

@@ tb/framebuffer_fill_engine_unit_tb.sv @@
// self-checking testbench for the framebuffer fill engine: random requests against a shadow surface
module framebuffer_fill_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffe_pkg::*;

  // kind code the engine must reject as out of bounds
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // random clears only go to surfaces whose H*(W+1) is within this budget
  localparam int unsigned CLEAR_BUDGET = 8200;
  localparam int unsigned CYCLE_LIMIT  = 5000000;
  localparam int unsigned SETTLE       = 32;
  localparam int unsigned RAND_PHASES  = 16;
  localparam int unsigned GOOD_ITEMS   = 12;
  localparam int unsigned BAD_ITEMS    = 3;
  localparam int unsigned N_BAD        = 8;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } paint_cmd_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [PIXEL_W-1:0] pixel;
  } pixel_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PITCH_W-1:0]   cfg_data;

  ffe_req_if req_ch ();
  ffe_rsp_if rsp_ch ();

  framebuffer_fill_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the pixel store and the surface registers; bit arrays start at zero
  bit [7:0]           shadow_mem [0:MEM_BYTES_DEF-1];
  logic [DIM_W-1:0]   surf_width  = '0;
  logic [DIM_W-1:0]   surf_height = '0;
  logic [PITCH_W-1:0] surf_pitch_reg = '0;

  paint_cmd_t    cmd_queue[$];         // requests waiting for the driver
  pixel_status_t expected_results[$];  // predicted results, oldest first

  int unsigned n_queued    = 0;
  int unsigned n_accepted  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned req_gap     = 0;
  int unsigned rsp_gap     = 0;
  bit          calm_phase  = 1'b0;   // no idling on either side while set
  logic        req_taken   = 1'b0;   // request handshake at the last rising edge
  logic        rsp_taken   = 1'b0;   // result handshake at the last rising edge

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // effective pitch and whether the configured surface is usable
  function automatic bit surface_valid(output int unsigned pitch);
    int unsigned w;
    int unsigned h;
    longint unsigned span;
    w = surf_width;
    h = surf_height;
    pitch = (surf_pitch_reg == '0) ? w * 4 : surf_pitch_reg;
    span = longint'(pitch) * h;
    if (w == 0 || h == 0) return 1'b0;
    if (w > MAX_WIDTH || h > MAX_HEIGHT) return 1'b0;
    if (pitch < w * 4 || pitch > MAX_PITCH) return 1'b0;
    if (span > MEM_BYTES_DEF) return 1'b0;
    return 1'b1;
  endfunction

  // pixels whose last byte falls past the store are dropped
  function automatic void paint_rect(int unsigned x0, int unsigned y0, int unsigned x1,
                                     int unsigned y1, int unsigned pitch,
                                     logic [PIXEL_W-1:0] rgba);
    int unsigned off;
    for (int unsigned row = y0; row < y1; row++) begin
      for (int unsigned col = x0; col < x1; col++) begin
        off = row * pitch + col * 4;
        if (off + 3 < MEM_BYTES_DEF) begin
          shadow_mem[off]     = rgba[7:0];
          shadow_mem[off + 1] = rgba[15:8];
          shadow_mem[off + 2] = rgba[23:16];
          shadow_mem[off + 3] = rgba[31:24];
        end
      end
    end
  endfunction

  function automatic pixel_status_t predict_result(paint_cmd_t c);
    pixel_status_t res;
    int unsigned pitch;
    int unsigned xs;
    int unsigned ys;
    int unsigned x_end;
    int unsigned y_end;
    int unsigned off;
    logic [PIXEL_W-1:0] rgba;
    res.status = ST_OK;
    res.pixel  = '0;
    xs = c.x;
    ys = c.y;
    x_end = xs + c.w;   // exact sums, no wrap at 16 bits
    y_end = ys + c.h;
    rgba = {c.alpha, c.blue, c.green, c.red};
    if (!surface_valid(pitch)) begin
      res.status = ST_INVALID;
    end else begin
      case (c.kind)
        KIND_CLEAR: begin
          paint_rect(0, 0, surf_width, surf_height, pitch, rgba);
        end
        KIND_FILL: begin
          // whole rectangle checked before any byte moves
          if (x_end > surf_width || y_end > surf_height) res.status = ST_OOB;
          else paint_rect(xs, ys, x_end, y_end, pitch, rgba);
        end
        KIND_READ: begin
          if (xs >= surf_width || ys >= surf_height) begin
            res.status = ST_OOB;
          end else begin
            off = ys * pitch + xs * 4;
            if (off + 3 < MEM_BYTES_DEF)
              res.pixel = {shadow_mem[off + 3], shadow_mem[off + 2],
                           shadow_mem[off + 1], shadow_mem[off]};
          end
        end
        default: begin
          res.status = ST_OOB;
        end
      endcase
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // idling: mostly back to back or short, now and then a long stretch
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver: payload changes on the falling edge, held until taken
  always @(negedge clk) begin : request_driver
    paint_cmd_t cmd;
    if (!rst && !(req_ch.valid && !req_taken)) begin
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cmd = cmd_queue.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= cmd.kind;
        req_ch.x_coord     <= cmd.x;
        req_ch.y_coord     <= cmd.y;
        req_ch.rect_width  <= cmd.w;
        req_ch.rect_height <= cmd.h;
        req_ch.red         <= cmd.red;
        req_ch.green       <= cmd.green;
        req_ch.blue        <= cmd.blue;
        req_ch.alpha       <= cmd.alpha;
        req_gap = idle_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result side: stalls after a taken result and at random while waiting
  always @(negedge clk) begin : result_sink
    if (rsp_gap == 0 && (rsp_taken || $urandom_range(0, 15) == 0))
      rsp_gap = idle_len();
    if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk) begin : result_monitor
    paint_cmd_t    seen;
    pixel_status_t want;
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    rsp_taken <= !rst && rsp_ch.valid && rsp_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      seen.kind  = req_ch.kind;
      seen.x     = req_ch.x_coord;
      seen.y     = req_ch.y_coord;
      seen.w     = req_ch.rect_width;
      seen.h     = req_ch.rect_height;
      seen.red   = req_ch.red;
      seen.green = req_ch.green;
      seen.blue  = req_ch.blue;
      seen.alpha = req_ch.alpha;
      expected_results.push_back(predict_result(seen));
      n_accepted++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d pixel %h",
                 $time, rsp_ch.status, rsp_ch.pixel_value);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.pixel_value !== want.pixel) begin
          $display("%0t: pixel_value mismatch, expected %h, got %h",
                   $time, want.pixel, rsp_ch.pixel_value);
          fail_count++;
        end
      end
    end
  end

  // covers the post-reset sweep and every request at its slowest, several times over
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one request with a random color
  task automatic queue_req(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] w,
                           logic [COORD_W-1:0] h);
    paint_cmd_t cmd;
    cmd.kind  = kind;
    cmd.x     = x;
    cmd.y     = y;
    cmd.w     = w;
    cmd.h     = h;
    cmd.red   = COLOR_W'($urandom_range(0, 255));
    cmd.green = COLOR_W'($urandom_range(0, 255));
    cmd.blue  = COLOR_W'($urandom_range(0, 255));
    cmd.alpha = COLOR_W'($urandom_range(0, 255));
    cmd_queue.push_back(cmd);
    n_queued++;
  endtask

  // every queued request taken and answered; sampled away from the rising edge
  task automatic drain();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[PITCH_W-1:0];
    case (idx)
      CFG_WIDTH:  surf_width     = value[DIM_W-1:0];
      CFG_HEIGHT: surf_height    = value[DIM_W-1:0];
      CFG_PITCH:  surf_pitch_reg = value[PITCH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reconfigure only with the engine idle; the store keeps its bytes
  task automatic set_surface(int unsigned w, int unsigned h, int unsigned pitch);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PITCH, pitch);
    calm_phase = ($urandom_range(0, 3) == 0);
  endtask

  // usable surface: tall, wide, full-store or small with optional row padding
  task automatic pick_good_surface(output int unsigned w, output int unsigned h,
                                   output int unsigned pitch);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      w = MAX_WIDTH;
      h = $urandom_range(1, 3);
      pitch = $urandom_range(0, 1) ? MAX_PITCH : 0;
    end else if (r == 1) begin
      w = $urandom_range(1, 3);
      h = MAX_HEIGHT;
      pitch = $urandom_range(0, 1) ? w * 4 + $urandom_range(0, 4) : 0;
    end else if (r == 2) begin
      // pitch times height lands exactly on the store size
      w = $urandom_range(256, MAX_WIDTH);
      h = 128;
      pitch = MAX_PITCH;
    end else begin
      w = $urandom_range(1, 48);
      h = $urandom_range(1, 48);
      pitch = $urandom_range(0, 1) ? w * 4 + $urandom_range(0, 9) : 0;
    end
  endtask

  // mostly well-formed requests on the current surface, some broken, some noise
  task automatic queue_random_req();
    int unsigned pitch;
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned rw;
    int unsigned rh;
    int unsigned pick;
    bit ok;
    bit cheap;
    logic [KIND_W-1:0] kind;
    ok = surface_valid(pitch);
    w = surf_width;
    h = surf_height;
    cheap = (h * (w + 1) <= CLEAR_BUDGET);
    pick = $urandom_range(0, 19);
    x  = $urandom_range(0, 65535);
    y  = $urandom_range(0, 65535);
    rw = $urandom_range(0, 65535);
    rh = $urandom_range(0, 65535);
    if (!ok || pick == 19) begin
      kind = KIND_W'($urandom_range(0, 3));
      if (ok && kind == KIND_CLEAR && !cheap) kind = KIND_READ;
    end else if (pick < 2 && cheap) begin
      // clear ignores coordinates, so they stay random
      kind = KIND_CLEAR;
    end else if (pick >= 2 && pick < 9) begin
      kind = KIND_FILL;
      x  = $urandom_range(0, w - 1);
      y  = $urandom_range(0, h - 1);
      rw = $urandom_range(0, (w - x < 16) ? w - x : 16);
      rh = $urandom_range(0, (h - y < 16) ? h - y : 16);
    end else if (pick < 16) begin
      kind = KIND_READ;
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
    end else if (pick == 16) begin
      // rectangle runs past one edge, possibly far past
      kind = KIND_FILL;
      x = $urandom_range(0, w - 1);
      y = $urandom_range(0, h - 1);
      if ($urandom_range(0, 1)) begin
        rw = $urandom_range(w - x + 1, $urandom_range(0, 1) ? 65535 : w - x + 3);
        rh = $urandom_range(0, 4);
      end else begin
        rw = $urandom_range(0, 4);
        rh = $urandom_range(h - y + 1, $urandom_range(0, 1) ? 65535 : h - y + 3);
      end
    end else if (pick == 17) begin
      kind = KIND_READ;
      if ($urandom_range(0, 1)) begin
        x = $urandom_range(w, 65535);
        y = $urandom_range(0, h - 1);
      end else begin
        x = $urandom_range(0, w - 1);
        y = $urandom_range(h, 65535);
      end
    end else begin
      kind = KIND_UNUSED;
    end
    queue_req(kind, x[COORD_W-1:0], y[COORD_W-1:0], rw[COORD_W-1:0], rh[COORD_W-1:0]);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned w;
    int unsigned h;
    int unsigned pitch;
    int unsigned bad_idx;
    int unsigned bad_w [N_BAD];
    int unsigned bad_h [N_BAD];
    int unsigned bad_p [N_BAD];

    // surfaces that break one rule each: too wide, too tall, just too wide,
    // empty, pitch too short, more rows than the store holds, pitch too long
    bad_w = '{4095, 4, 2049, 0, 5, 4, 8, 4};
    bad_h = '{4, 4095, 1, 5, 0, 4, 129, 4};
    bad_p = '{0, 0, 0, 0, 0, 15, 8192, 8196};

    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_CLEAR;
    req_ch.x_coord     = '0;
    req_ch.y_coord     = '0;
    req_ch.rect_width  = '0;
    req_ch.rect_height = '0;
    req_ch.red         = '0;
    req_ch.green       = '0;
    req_ch.blue        = '0;
    req_ch.alpha       = '0;
    rsp_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_WIDTH;
    cfg_data           = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still zero after reset: invalid surface wins over the unused kind
    queue_req(KIND_READ, 0, 0, 0, 0);
    queue_req(KIND_UNUSED, 0, 0, 0, 0);

    // small packed surface: every operation and every bounds rule
    set_surface(4, 3, 0);
    queue_req(KIND_READ, 0, 0, 0, 0);               // store still zero
    queue_req(KIND_CLEAR, 0, 0, 0, 0);
    queue_req(KIND_READ, 3, 2, 0, 0);               // far corner after clear
    queue_req(KIND_FILL, 1, 1, 2, 2);
    queue_req(KIND_READ, 2, 2, 0, 0);
    queue_req(KIND_READ, 0, 0, 0, 0);               // outside the fill
    queue_req(KIND_FILL, 4, 3, 0, 0);               // empty fill at the far edge
    queue_req(KIND_FILL, 0, 0, 0, 5);               // empty but too tall
    queue_req(KIND_FILL, 3, 0, 2, 1);               // one column past the edge
    queue_req(KIND_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // sums exceed 16 bits
    queue_req(KIND_READ, 4, 0, 0, 0);
    queue_req(KIND_READ, 0, 16'hFFFF, 0, 0);
    queue_req(KIND_UNUSED, 1, 1, 1, 1);

    // odd padded pitch over the old bytes: pixels land unaligned
    set_surface(3, 2, 13);
    queue_req(KIND_READ, 1, 1, 0, 0);
    queue_req(KIND_FILL, 1, 0, 2, 2);
    queue_req(KIND_READ, 2, 1, 0, 0);

    // widest row
    set_surface(MAX_WIDTH, 1, 0);
    queue_req(KIND_CLEAR, 0, 0, 0, 0);
    queue_req(KIND_READ, COORD_W'(MAX_WIDTH - 1), 0, 0, 0);

    // tallest column
    set_surface(1, MAX_HEIGHT, 0);
    queue_req(KIND_FILL, 0, COORD_W'(MAX_HEIGHT - 8), 1, 8);
    queue_req(KIND_READ, 0, COORD_W'(MAX_HEIGHT - 1), 0, 0);

    // largest pitch filling the whole store: last pixel ends on the last byte
    set_surface(MAX_WIDTH, 128, MAX_PITCH);
    queue_req(KIND_FILL, COORD_W'(MAX_WIDTH - 8), 120, 8, 8);
    queue_req(KIND_READ, COORD_W'(MAX_WIDTH - 1), 127, 0, 0);

    // random phases, every other one on a broken surface while the list lasts
    bad_idx = 0;
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase % 2 == 1 && bad_idx < N_BAD) begin
        set_surface(bad_w[bad_idx], bad_h[bad_idx], bad_p[bad_idx]);
        bad_idx++;
        repeat (BAD_ITEMS) queue_random_req();
      end else begin
        pick_good_surface(w, h, pitch);
        set_surface(w, h, pitch);
        repeat (GOOD_ITEMS) queue_random_req();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
